// File: hdl/earliest_event_queue_assert.svh
// ---------------------------------------------------------------------------
// earliest_event_queue_assert.svh
// assertion macros used by the checker file of the event queue
// ---------------------------------------------------------------------------
`ifndef EARLIEST_EVENT_QUEUE_ASSERT_SVH
`define EARLIEST_EVENT_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define EEQ_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define EEQ_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hdl/eeq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eeq_pkg
// types, sizes and codes of the earliest-event queue
// ---------------------------------------------------------------------------
package eeq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int MAX_NODES   = 1024;
  localparam int MAX_DAY     = 4095;

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int NODE_W = 10;
  localparam int TIME_W = 12;

  localparam logic [NODE_W-1:0] NODE_MAX = NODE_W'(MAX_NODES - 1);
  localparam logic [TIME_W-1:0] DAY_MAX  = TIME_W'(MAX_DAY);

  // node in the low bits, matching the stream layout
  typedef struct packed {
    logic [TIME_W-1:0] day;
    logic              action;
    logic [NODE_W-1:0] node;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam int IN_TDATA_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ENTRY_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - ENTRY_W - CNT_W;
  localparam int OUT_TUSER_W = 2;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_run;
    logic shift_start;
    logic shift_run;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic req_extract;
    logic empty;
    logic scan_done;
    logic shift_done;
    logic out_free;
  } status_t;

endpackage

// File: hdl/eeq_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eeq_ram
// generic simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module eeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/eeq_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eeq_ctrl
// sequencer: accept, scan for the earliest entry, close the gap, report
// ---------------------------------------------------------------------------
module eeq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  eeq_pkg::status_t status,
  output eeq_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (status.req_extract && !status.empty) begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          cmd.shift_start = 1'b1;
          state_next      = ST_SHIFT;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (status.shift_done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.shift_run = 1'b1;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/eeq_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eeq_datapath
// event store, count, minimum scan, gap closing and result register
// ---------------------------------------------------------------------------
module eeq_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [eeq_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                               s_tuser,
  input  logic                               m_tready,
  input  eeq_pkg::cmd_t                      cmd,
  output eeq_pkg::status_t                   status,
  output logic                               m_tvalid,
  output logic [eeq_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic [eeq_pkg::OUT_TUSER_W-1:0]    m_tuser
);

  eeq_pkg::entry_t item, best, rdata, wdata, in_entry;
  logic item_kind;

  logic [eeq_pkg::CNT_W-1:0]  count, count_next;
  logic [eeq_pkg::CNT_W-1:0]  scan_left, shift_left, src, dest;
  logic [eeq_pkg::ADDR_W-1:0] scan_idx, rd_idx, best_idx, raddr, waddr;
  logic rd_v, first, we, full, empty, got, ovf, ins_ok;

  assign in_entry = eeq_pkg::entry_t'(s_tdata[eeq_pkg::ENTRY_W-1:0]);

  assign full   = (count >= eeq_pkg::CNT_W'(eeq_pkg::QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign ins_ok = (item_kind == eeq_pkg::KIND_INSERT) && !full;
  assign got    = (item_kind == eeq_pkg::KIND_EXTRACT) && !empty;
  assign ovf    = (item_kind == eeq_pkg::KIND_INSERT) && full;
  assign dest   = src - eeq_pkg::CNT_W'(1);

  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + eeq_pkg::CNT_W'(1);
    end else if (got) begin
      count_next = count - eeq_pkg::CNT_W'(1);
    end
  end

  assign status.req_extract = (s_tuser == eeq_pkg::KIND_EXTRACT);
  assign status.empty       = empty;
  assign status.scan_done   = (scan_left == '0) && !rd_v;
  assign status.shift_done  = (shift_left == '0) && !rd_v;
  assign status.out_free    = !m_tvalid || m_tready;

  // shift copies entry src into src-1, insert writes at the tail
  assign raddr = cmd.shift_run ? src[eeq_pkg::ADDR_W-1:0] : scan_idx;
  assign we    = (cmd.shift_run && rd_v) || (cmd.commit && ins_ok);
  assign waddr = cmd.shift_run ? rd_idx : count[eeq_pkg::ADDR_W-1:0];
  assign wdata = cmd.shift_run ? rdata : item;

  eeq_ram #(
    .WIDTH (eeq_pkg::ENTRY_W),
    .DEPTH (eeq_pkg::QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rd_v       <= 1'b0;
      scan_left  <= '0;
      shift_left <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
        count    <= count_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.scan_start) begin
        scan_left <= count;
        rd_v      <= 1'b0;
      end else if (cmd.scan_run) begin
        rd_v <= (scan_left != '0);
        if (scan_left != '0) begin
          scan_left <= scan_left - eeq_pkg::CNT_W'(1);
        end
      end else if (cmd.shift_start) begin
        shift_left <= count - eeq_pkg::CNT_W'(1) - eeq_pkg::CNT_W'(best_idx);
        rd_v       <= 1'b0;
      end else if (cmd.shift_run) begin
        rd_v <= (shift_left != '0);
        if (shift_left != '0) begin
          shift_left <= shift_left - eeq_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_kind   <= s_tuser;
      item.action <= in_entry.action;
      item.node   <= (in_entry.node > eeq_pkg::NODE_MAX) ? eeq_pkg::NODE_MAX : in_entry.node;
      item.day    <= (in_entry.day > eeq_pkg::DAY_MAX) ? eeq_pkg::DAY_MAX : in_entry.day;
    end
    if (cmd.scan_start) begin
      scan_idx <= eeq_pkg::ADDR_W'(count - eeq_pkg::CNT_W'(1));
      first    <= 1'b1;
    end
    if (cmd.scan_run) begin
      rd_idx   <= scan_idx;
      scan_idx <= scan_idx - eeq_pkg::ADDR_W'(1);
      // newest first, strict less keeps the newest on equal days
      if (rd_v) begin
        first <= 1'b0;
        if (first || (rdata.day < best.day)) begin
          best     <= rdata;
          best_idx <= rd_idx;
        end
      end
    end
    if (cmd.shift_start) begin
      src <= eeq_pkg::CNT_W'(best_idx) + eeq_pkg::CNT_W'(1);
    end
    if (cmd.shift_run) begin
      rd_idx <= dest[eeq_pkg::ADDR_W-1:0];
      src    <= src + eeq_pkg::CNT_W'(1);
    end
    if (cmd.commit) begin
      m_tdata <= {{eeq_pkg::OUT_PAD_W{1'b0}}, count_next, (got ? best : '0)};
      m_tuser <= {ovf, got};
    end
  end

endmodule

// File: hdl/earliest_event_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// earliest_event_queue
// event timeline: inserts events, extracts the one with the earliest day
// ---------------------------------------------------------------------------
//
// channel  dir  handshake           tdata (low bit up)               tuser
// s        in   s_tvalid/s_tready   node_id, action_type, event_time kind
// m        out  m_tvalid/m_tready   out_node, out_action, out_time,  got_event,
//                                   occupancy                        overflow
//
// one item at a time; an insert or an empty extract goes from idle straight to finish
// an extract over held entries scans them all for the earliest, then closes the gap
//   it leaves when it is not the newest entry, paced by the one-read-a-cycle
//   port of the store (scan, then gap closing)
// the result register lets the next item in while a result waits
// rst (synchronous) empties the queue; store contents are not cleared
// m_tready low holds the result and delays only the next item's finish
//
module earliest_event_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // node_id[9:0], action_type[10], event_time[22:11], zero pad
  input  logic [eeq_pkg::IN_TDATA_W-1:0]     s_tdata,
  // kind
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_node[9:0], out_action[10], out_time[22:11], occupancy[29:23], zero pad
  output logic [eeq_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // got_event[0], overflow[1]
  output logic [eeq_pkg::OUT_TUSER_W-1:0]    m_tuser
);

  eeq_pkg::cmd_t    cmd;
  eeq_pkg::status_t status;

  // sequencer: idle, scan, shift, finish
  eeq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // store, count, minimum search and result register
  eeq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: hdl/eeq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eeq_checker
// port-level checks of the event queue, bound to the top level
// ---------------------------------------------------------------------------
`include "earliest_event_queue_assert.svh"

module eeq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [eeq_pkg::IN_TDATA_W-1:0]  s_tdata,
  input logic                            s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [eeq_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [eeq_pkg::OUT_TUSER_W-1:0] m_tuser
);

  logic in_fire;
  assign in_fire = s_tvalid && s_tready && (s_tdata[0] || !s_tdata[0]) && (s_tuser || !s_tuser);

  `EEQ_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `EEQ_ASSERT_IMP(a_got_ovf_excl, m_tvalid, !(m_tuser[0] && m_tuser[1]), "got_event and overflow both set")
  `EEQ_ASSERT_IMP(a_ovf_full, m_tvalid && m_tuser[1], m_tdata[29:23] == eeq_pkg::CNT_W'(eeq_pkg::QUEUE_DEPTH), "overflow below full occupancy")
  `EEQ_ASSERT_IMP(a_no_event_zero, m_tvalid && !m_tuser[0], m_tdata[22:0] == '0, "event fields set without an event")
  `EEQ_ASSERT_NXT(a_one_at_a_time, in_fire, !s_tready, "second item taken in the next cycle")

endmodule

bind earliest_event_queue eeq_checker u_eeq_checker (.*);
